>>> sv/rlte_pkg.sv
// Shared types and constants for the rating list tuple expander.
// Holds key buffer sizing, register indexes and the controller/datapath interface.
// No dependencies.
package rlte_pkg;

  localparam int unsigned KEY_BYTES = 16;
  localparam int unsigned KLEN_W    = $clog2(KEY_BYTES + 1);
  localparam int unsigned KIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] RST_SEGMENT_SEP = 8'd124;
  localparam logic [7:0] RST_KEY_SEP     = 8'd58;
  localparam logic [7:0] RST_ITEM_SEP    = 8'd59;
  localparam logic [7:0] RST_FIELD_MARK  = 8'd31;
  localparam logic [7:0] RST_RECORD_MARK = 8'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT_SEP = 3'd0,
    REG_KEY_SEP     = 3'd1,
    REG_ITEM_SEP    = 3'd2,
    REG_FIELD_MARK  = 3'd3,
    REG_RECORD_MARK = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_KEY,
    SEL_FIELD,
    SEL_RECORD,
    SEL_BYTE
  } out_sel_e;

  typedef struct packed {
    logic     accept;
    logic     rep_clr;
    logic     rep_inc;
    logic     load;
    out_sel_e sel;
    logic     run_last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_seg;
    logic items;
    logic pend;
    logic len_zero;
    logic byte_item;
    logic byte_last;
    logic rep_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/rlte_dpath.sv
// Datapath of the tuple expander: configuration registers, key buffer,
// segment state, replay counter and the output word register. Uses rlte_pkg.
module rlte_dpath import rlte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 token_last_i,
  input  logic                 out_ready_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 run_last_o,
  output logic                 token_end_o,
  output logic                 key_overflow_o
);

  logic [7:0] seg_sep_q, key_sep_q, item_sep_q, field_mark_q, record_mark_q;

  logic [7:0]        key_store [KEY_BYTES];
  logic [KLEN_W-1:0] len_q, len_d;
  logic              items_q, items_d;
  logic              pend_q, pend_d;
  logic              ovf_q, ovf_d;
  logic              ovf_word_d;
  logic              store_en;

  logic [7:0]        byte_q;
  logic              last_q;
  logic              item_q;
  logic              ovf_word_q;
  logic [KLEN_W-1:0] rep_len_q;
  logic [KIDX_W-1:0] rep_idx_q;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              run_last_q, token_end_q, ovf_out_q;

  logic is_seg, is_key, is_item;
  logic [7:0] out_byte_d;

  assign is_seg  = (in_byte_i == seg_sep_q);
  assign is_key  = (in_byte_i == key_sep_q);
  assign is_item = (in_byte_i == item_sep_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_sep_q     <= RST_SEGMENT_SEP;
      key_sep_q     <= RST_KEY_SEP;
      item_sep_q    <= RST_ITEM_SEP;
      field_mark_q  <= RST_FIELD_MARK;
      record_mark_q <= RST_RECORD_MARK;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SEGMENT_SEP: seg_sep_q     <= cfg_data_i;
        REG_KEY_SEP:     key_sep_q     <= cfg_data_i;
        REG_ITEM_SEP:    item_sep_q    <= cfg_data_i;
        REG_FIELD_MARK:  field_mark_q  <= cfg_data_i;
        REG_RECORD_MARK: record_mark_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Segment state is updated in full when the word is taken; the replay
  // length and overflow flag for the outputs are captured alongside.
  always_comb begin
    len_d      = len_q;
    items_d    = items_q;
    pend_d     = pend_q;
    ovf_d      = ovf_q;
    store_en   = 1'b0;
    ovf_word_d = ovf_q;
    if (!is_seg) begin
      if (!items_q) begin
        if (is_key) begin
          items_d = 1'b1;
          pend_d  = 1'b1;
        end else if (len_q < KLEN_W'(KEY_BYTES)) begin
          store_en = 1'b1;
          len_d    = len_q + KLEN_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        pend_d = is_item;
      end
      ovf_word_d = ovf_d;
    end
    if (is_seg || token_last_i) begin
      items_d = 1'b0;
      len_d   = '0;
      pend_d  = 1'b1;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      items_q <= 1'b0;
      pend_q  <= 1'b1;
      ovf_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      len_q   <= len_d;
      items_q <= items_d;
      pend_q  <= pend_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store_en) begin
      key_store[len_q[KIDX_W-1:0]] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q     <= in_byte_i;
      last_q     <= token_last_i;
      item_q     <= is_item;
      ovf_word_q <= ovf_word_d;
      rep_len_q  <= len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_idx_q <= '0;
    end else if (cmd_i.rep_clr) begin
      rep_idx_q <= '0;
    end else if (cmd_i.rep_inc) begin
      rep_idx_q <= rep_idx_q + KIDX_W'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_KEY:    out_byte_d = key_store[rep_idx_q];
      SEL_FIELD:  out_byte_d = field_mark_q;
      SEL_RECORD: out_byte_d = record_mark_q;
      SEL_BYTE:   out_byte_d = byte_q;
      default:    out_byte_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q  <= out_byte_d;
      run_last_q  <= cmd_i.run_last;
      token_end_q <= cmd_i.run_last & last_q;
      ovf_out_q   <= ovf_word_q;
    end
  end

  assign stat_o.in_seg    = is_seg;
  assign stat_o.items     = items_q;
  assign stat_o.pend      = pend_q;
  assign stat_o.len_zero  = (len_q == '0);
  assign stat_o.byte_item = item_q;
  assign stat_o.byte_last = last_q;
  assign stat_o.rep_done  = ((KLEN_W'(rep_idx_q) + KLEN_W'(1)) == rep_len_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign run_last_o     = run_last_q;
  assign token_end_o    = token_end_q;
  assign key_overflow_o = ovf_out_q;

endmodule

>>> sv/rlte_ctrl.sv
// Sequencing controller of the tuple expander: takes input words and steps
// through the output words each one causes. Uses rlte_pkg.
module rlte_ctrl import rlte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     token_last_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_KEY,
    ST_FIELD,
    ST_BODY,
    ST_TAIL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_RECORD;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_seg) begin
            state_d = ST_SEG;
          end else if (stat_i.items && stat_i.pend) begin
            // A new tuple opens: replay the key, then the field mark.
            cmd_o.rep_clr = 1'b1;
            state_d = stat_i.len_zero ? ST_FIELD : ST_KEY;
          end else if (stat_i.items) begin
            state_d = ST_BODY;
          end else if (token_last_i) begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_SEG: begin
        cmd_o.run_last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_KEY: begin
        cmd_o.sel = SEL_KEY;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          if (stat_i.rep_done) begin
            state_d = ST_FIELD;
          end else begin
            cmd_o.rep_inc = 1'b1;
          end
        end
      end
      ST_FIELD: begin
        cmd_o.sel = SEL_FIELD;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_BODY;
        end
      end
      ST_BODY: begin
        cmd_o.sel      = stat_i.byte_item ? SEL_RECORD : SEL_BYTE;
        cmd_o.run_last = !stat_i.byte_last;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = stat_i.byte_last ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        cmd_o.run_last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/rating_list_tuple_expander.sv
// Rating list tuple expander: turns key:item;item|key:item token words into
// key, field mark, item, record mark tuples.
//
// Input channel (in_valid_i/in_ready_o) takes one token byte per word with
// token_last_i on the final byte. Output channel (out_valid_o/out_ready_i)
// gives one byte per word; run_last_o marks the last word caused by an input
// word, token_end_o the last word of the token, key_overflow_o a key that was
// cut to KEY_BYTES bytes. The user must write the configuration registers
// through cfg_we_i/cfg_index_i/cfg_data_i while the block is idle; not enforced.
//
// One input word is handled at a time: it is registered when taken, and no new
// input word is taken until the last output word it causes has been loaded.
// A key byte gives no output unless it is the token's last byte, which adds a
// record mark; a segment separator gives one record mark. An item byte gives
// one word, plus a record mark on the token's last byte, plus key length + 1
// words at the start of each tuple while the stored key is replayed one byte
// per cycle if not stalled. Output words leave through a single output
// register, so a stalled receiver holds the sequencer until the word is taken.
// Reset restores the default separators and marks and starts in key phase.
module rating_list_tuple_expander import rlte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 token_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 run_last_o,
  output logic                 token_end_o,
  output logic                 key_overflow_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rlte_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .token_last_i (token_last_i),
    .in_ready_o   (in_ready_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  rlte_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_byte_i      (in_byte_i),
    .token_last_i   (token_last_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .token_end_o    (token_end_o),
    .key_overflow_o (key_overflow_o)
  );

  // The output register is never overwritten while it holds an untaken word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || out_ready_i))
    else $error("output word overwritten before it was taken");

  // The last byte of a token always produces at least one output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && token_last_i) |=> !in_ready_o)
    else $error("last token byte produced no output");

  // The token end flag only appears on the closing word of an input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_end_o) |-> run_last_o)
    else $error("token end without run end");

endmodule

>>> tb/rating_list_tuple_expander_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rating_list_tuple_expander: directed and random tokens,
// predicted tuples compared word by word on the output channel. Depends on rlte_pkg.
module rating_list_tuple_expander_test;
  import rlte_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_WORDS    = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       token_end;
    logic       key_overflow;
  } tuple_word_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [5:0]  reps;
    logic        typed;
    tuple_word_t word;
  } stim_row_t;

  // Typed words only where the result is obvious; other rows use the predictor.
  localparam stim_row_t DIRECTED [11] = '{
    '{RST_SEGMENT_SEP, 1'b1, 6'd1, 1'b1, '{RST_RECORD_MARK, 1'b1, 1'b1, 1'b0}},
    '{8'h61,           1'b1, 6'd1, 1'b1, '{RST_RECORD_MARK, 1'b1, 1'b1, 1'b0}},
    '{8'h00,           1'b0, 6'd1, 1'b0, '0},
    '{8'hFF,           1'b0, 6'd1, 1'b0, '0},
    '{RST_KEY_SEP,     1'b0, 6'd1, 1'b0, '0},
    '{RST_ITEM_SEP,    1'b0, 6'd1, 1'b0, '0},
    '{8'hFF,           1'b1, 6'd1, 1'b0, '0},
    '{8'h6B,           1'b0, 6'(KEY_BYTES + 1), 1'b0, '0},
    '{RST_KEY_SEP,     1'b0, 6'd1, 1'b0, '0},
    '{8'h00,           1'b0, 6'd1, 1'b0, '0},
    '{RST_SEGMENT_SEP, 1'b0, 6'd1, 1'b1, '{RST_RECORD_MARK, 1'b1, 1'b0, 1'b1}}
  };

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  cfg_reg_e    cfg_index_i  = REG_SEGMENT_SEP;
  logic [7:0]  cfg_data_i   = 8'h00;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i    = 8'h00;
  logic        token_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        token_end_o;
  logic        key_overflow_o;

  // Travels with the payload so the checker knows which rows carry a typed result.
  logic        row_typed = 1'b0;
  tuple_word_t row_word  = '0;

  // Mirror of the configuration registers.
  logic [7:0] seg_sep     = RST_SEGMENT_SEP;
  logic [7:0] key_sep     = RST_KEY_SEP;
  logic [7:0] item_sep    = RST_ITEM_SEP;
  logic [7:0] field_byte  = RST_FIELD_MARK;
  logic [7:0] record_byte = RST_RECORD_MARK;

  // Mirror of the segment state.
  logic        after_colon = 1'b0;
  logic [7:0]  key_buf [KEY_BYTES];
  int unsigned key_len     = 0;
  logic        need_key    = 1'b1;
  logic        key_cut     = 1'b0;

  tuple_word_t step_words [$];
  tuple_word_t expected_words [$];
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          steady      = 1'b0;

  rating_list_tuple_expander i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .token_last_i   (token_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .token_end_o    (token_end_o),
    .key_overflow_o (key_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void emit_word(input logic [7:0] d);
    step_words.push_back('{d, 1'b0, 1'b0, key_cut});
  endfunction

  function automatic void clear_segment();
    after_colon = 1'b0;
    key_len     = 0;
    need_key    = 1'b1;
    key_cut     = 1'b0;
  endfunction

  // Expands one accepted byte into the words it should produce.
  task automatic expand_byte(input logic [7:0] b, input logic l, input logic typed,
                             input tuple_word_t typed_word);
    step_words.delete();
    if (b == seg_sep) begin
      emit_word(record_byte);
      clear_segment();
    end else begin
      if (!after_colon) begin
        if (b == key_sep) begin
          after_colon = 1'b1;
          need_key    = 1'b1;
        end else if (key_len < KEY_BYTES) begin
          key_buf[key_len] = b;
          key_len++;
        end else begin
          key_cut = 1'b1;
        end
      end else begin
        if (need_key) begin
          for (int unsigned k = 0; k < key_len; k++) emit_word(key_buf[k]);
          emit_word(field_byte);
          need_key = 1'b0;
        end
        if (b == item_sep) begin
          emit_word(record_byte);
          need_key = 1'b1;
        end else begin
          emit_word(b);
        end
      end
      if (l) begin
        emit_word(record_byte);
        clear_segment();
      end
    end
    if (step_words.size() > 0) begin
      step_words[$].run_last  = 1'b1;
      step_words[$].token_end = l;
    end
    if (typed) expected_words.push_back(typed_word);
    else foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  // Watches both channels and the register port; predicts and checks.
  always @(posedge clk_i) begin : scoreboard
    tuple_word_t got;
    tuple_word_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_we_i) begin
        idle_cycles = 0;
        case (cfg_index_i)
          REG_SEGMENT_SEP: seg_sep     = cfg_data_i;
          REG_KEY_SEP:     key_sep     = cfg_data_i;
          REG_ITEM_SEP:    item_sep    = cfg_data_i;
          REG_FIELD_MARK:  field_byte  = cfg_data_i;
          REG_RECORD_MARK: record_byte = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        idle_cycles = 0;
        expand_byte(in_byte_i, token_last_i, row_typed, row_word);
      end
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        got = '{out_byte_o, run_last_o, token_end_o, key_overflow_o};
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: byte %h run_last %b token_end %b overflow %b",
                     got.data, got.run_last, got.token_end, got.key_overflow);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected byte %h run_last %b token_end %b overflow %b, got %h %b %b %b",
                       want.data, want.run_last, want.token_end, want.key_overflow,
                       got.data, got.run_last, got.token_end, got.key_overflow);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("rating_list_tuple_expander_test: errors");
        $finish;
      end
    end
  end

  // Receiver: stalls at random about 8 percent of the time unless in a steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 8);
  end

  task automatic send_word(input logic [7:0] b, input logic l, input logic typed,
                           input tuple_word_t tw);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    token_last_i <= l;
    row_typed    <= typed;
    row_word     <= tw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Holds the sender until every expected word is out and the block is quiet.
  // The first edge lets the checker log the word taken at the current edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] seg, input logic [7:0] key,
                            input logic [7:0] item, input logic [7:0] fld,
                            input logic [7:0] rec);
    cfg_reg_e   idx [5];
    logic [7:0] val [5];
    idx = '{REG_SEGMENT_SEP, REG_KEY_SEP, REG_ITEM_SEP, REG_FIELD_MARK, REG_RECORD_MARK};
    val = '{seg, key, item, fld, rec};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == seg_sep || b == key_sep || b == item_sep) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // A well-formed token with random content, sometimes missing its key separator
  // or carrying an over-long key; or else a run of noise bytes.
  task automatic send_token(input bit noisy);
    logic [7:0]  tok [$];
    int unsigned klen;
    int unsigned nitems;
    int unsigned n;
    int unsigned pick;
    if (noisy) begin
      n = $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++) begin
        pick = $urandom_range(0, 5);
        send_word(pick == 0 ? seg_sep : pick == 1 ? key_sep : pick == 2 ? item_sep :
                  8'($urandom_range(0, 255)),
                  (i == n - 1) || ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
    end else begin
      for (int s = 0; s < int'($urandom_range(1, 3)); s++) begin
        if (s > 0) tok.push_back(seg_sep);
        klen = ($urandom_range(0, 9) == 0) ? $urandom_range(KEY_BYTES - 2, KEY_BYTES + 4)
                                           : $urandom_range(0, 5);
        repeat (klen) tok.push_back(plain_byte());
        if ($urandom_range(0, 9) != 0) begin
          tok.push_back(key_sep);
          nitems = $urandom_range(1, 3);
          for (int unsigned it = 0; it < nitems; it++) begin
            if (it > 0) tok.push_back(item_sep);
            repeat ($urandom_range(0, 4)) tok.push_back(plain_byte());
          end
        end
      end
      if ($urandom_range(0, 7) == 0) tok.push_back(seg_sep);
      if (tok.size() == 0) tok.push_back(plain_byte());
      foreach (tok[i]) send_word(tok[i], i == tok.size() - 1, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  r;
    int unsigned target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      repeat (DIRECTED[i].reps)
        send_word(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].word);
    drain();

    for (int phase = 1; phase <= 6; phase++) begin
      r = 8'($urandom_range(0, 255));
      case (phase)
        1: write_regs(8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF);
        2: write_regs(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00);
        // Key and item separators share a value: each wins only in its own phase.
        3: write_regs(r ^ 8'h55, r, r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        // All separators equal: the segment separator always takes precedence.
        4: write_regs(r, r, r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        5: write_regs(RST_SEGMENT_SEP, RST_KEY_SEP, RST_ITEM_SEP, RST_FIELD_MARK,
                      RST_RECORD_MARK);
        default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
      endcase
      steady = (phase == 2);
      target = items_sent + PHASE_WORDS;
      send_token(1'b0);
      drain();
      while (items_sent < target) begin
        send_token($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) drain();
      end
      drain();
    end
    steady = 1'b0;

    if (errors == 0 && expected_words.size() == 0) begin
      $display("rating_list_tuple_expander_test: clean");
    end else begin
      $display("rating_list_tuple_expander_test: errors");
    end
    $finish;
  end

endmodule
